// File: rtl/delta_list_task_scheduler_macros.svh
// Assertion macros for the delta-list task scheduler.
`ifndef DELTA_LIST_TASK_SCHEDULER_MACROS_SVH
`define DELTA_LIST_TASK_SCHEDULER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define DLTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("delta list scheduler check failed");

// Consequent must hold in the cycle after the antecedent.
`define DLTS_ASSERT_NEXT(lbl, ante, cons) \
    `DLTS_ASSERT(lbl, (ante) |=> (cons))

`endif

// File: rtl/dlts_pkg.sv
// Shared types and constants for the delta-list task scheduler.
package dlts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int AW        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW        = $clog2(MAX_TASKS + 1);

    // action codes
    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_ADD      = 3'd1;
    localparam logic [2:0] ACT_DISPATCH = 3'd2;
    localparam logic [2:0] ACT_DELETE   = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTREADY = 2'd3;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] delta;
        logic [15:0] period;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// File: rtl/delta_list_task_scheduler.sv
// Top level of the delta-list task scheduler: sequencer, shared adder and entry RAM.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+---------------------------
//  command | i_action i_task_id i_first_delay              | taken when start && !busy
//          | i_repeat_period i_position                    |
//  result  | o_ran_task o_run_id o_status o_task_count     | o_result_valid, one cycle
//
// Steps per command: clear, tick on an empty queue and rejected deletes or dispatches
// go straight to the result; an add to a full queue stops at the count check; a tick
// reads the head and writes it back counted down; a delete reads the removed entry,
// folds its delay into the follower and shifts the entries behind it down; an add
// compares entries, splits a delay, shifts entries up and writes the new one; a periodic
// dispatch is a remove plus an add. Reset is synchronous and empties the queue at once.
// busy stays high until the result strobe; results cannot be stalled.
`include "delta_list_task_scheduler_macros.svh"

module delta_list_task_scheduler import dlts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_first_delay,
    input  logic [15:0] i_repeat_period,
    input  logic [3:0]  i_position,
    output logic        o_result_valid,
    output logic        o_ran_task,
    output logic [7:0]  o_run_id,
    output logic [1:0]  o_status,
    output logic [4:0]  o_task_count
);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_TK_RD     = 4'd1;
    localparam logic [3:0] S_TK_WR     = 4'd2;
    localparam logic [3:0] S_RM_RD     = 4'd3;
    localparam logic [3:0] S_RM_GONE   = 4'd4;
    localparam logic [3:0] S_RM_SH     = 4'd5;
    localparam logic [3:0] S_RM_END    = 4'd6;
    localparam logic [3:0] S_INS_RD    = 4'd7;
    localparam logic [3:0] S_INS_CMP   = 4'd8;
    localparam logic [3:0] S_INS_SPLIT = 4'd9;
    localparam logic [3:0] S_SH_RD     = 4'd10;
    localparam logic [3:0] S_SH_WR     = 4'd11;
    localparam logic [3:0] S_INS_PUT   = 4'd12;
    localparam logic [3:0] S_FIN       = 4'd13;

    // control state
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_head_ready, n_head_ready;
    logic          r_valid, n_valid;

    // item payload and walk registers
    logic [2:0]    r_act, n_act;
    logic [7:0]    r_id, n_id;
    logic [15:0]   r_delay, n_delay;
    logic [15:0]   r_period, n_period;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_split, n_split;
    logic [15:0]   r_gone, n_gone;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_k, n_k;
    logic [1:0]    r_status, n_status;
    logic          r_ran, n_ran;
    logic [7:0]    r_run_id, n_run_id;

    // RAM port
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    t_entry             ram_wdata, rd;
    logic [ENTRY_W-1:0] ram_rdata;

    // shared adder
    logic [15:0] u_a, u_b, u_res;
    logic        u_sub, u_carry;
    logic [16:0] u_sum;

    // widened helpers for count compares
    logic [CW:0]   cnt_x, pos_p1, k_p2;
    logic [CW+3:0] in_pos_x, cnt_px;
    logic [CW+4:0] cnt_out;
    logic [CW-1:0] pos_inc, k_m1, k_m2, cnt_m1;

    assign rd       = t_entry'(ram_rdata);
    assign cnt_x    = {1'b0, r_cnt};
    assign pos_p1   = {1'b0, r_pos} + (CW+1)'(1);
    assign k_p2     = {1'b0, r_k} + (CW+1)'(2);
    assign in_pos_x = {{CW{1'b0}}, i_position};
    assign cnt_px   = {4'b0000, r_cnt};
    assign pos_inc  = r_pos + CW'(1);
    assign k_m1     = r_k - CW'(1);
    assign k_m2     = r_k - CW'(2);
    assign cnt_m1   = r_cnt - CW'(1);

    // operand select for the shared adder
    always_comb begin
        u_a   = 16'd0;
        u_b   = 16'd0;
        u_sub = 1'b1;
        unique case (r_state)
            S_INS_CMP: begin
                u_a = r_rem;
                u_b = rd.delta;
            end
            S_INS_SPLIT: begin
                u_a = rd.delta;
                u_b = r_rem;
            end
            S_TK_WR: begin
                u_a = rd.delta;
                u_b = 16'd1;
            end
            S_RM_SH: begin
                u_a   = rd.delta;
                u_b   = r_gone;
                u_sub = 1'b0;
            end
            default: begin
                u_a = 16'd0;
            end
        endcase
    end

    // add saturates high, subtract clamps at zero; carry is "no borrow" on subtract
    assign u_sum   = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + {16'd0, u_sub};
    assign u_carry = u_sum[16];
    assign u_res   = u_sub ? (u_carry ? u_sum[15:0] : 16'd0)
                           : (u_carry ? 16'hFFFF : u_sum[15:0]);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_head_ready = r_head_ready;
        n_valid      = 1'b0;
        n_act        = r_act;
        n_id         = r_id;
        n_delay      = r_delay;
        n_period     = r_period;
        n_rem        = r_rem;
        n_split      = r_split;
        n_gone       = r_gone;
        n_pos        = r_pos;
        n_k          = r_k;
        n_status     = r_status;
        n_ran        = r_ran;
        n_run_id     = r_run_id;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = rd;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_act    = i_action;
                    n_id     = i_task_id;
                    n_delay  = i_first_delay;
                    n_period = i_repeat_period;
                    n_status = ST_OK;
                    n_ran    = 1'b0;
                    n_run_id = 8'd0;
                    n_state  = S_FIN;
                    unique case (i_action)
                        ACT_TICK: begin
                            if (r_cnt != '0) n_state = S_TK_RD;
                        end
                        ACT_ADD: begin
                            n_state = S_INS_RD;
                        end
                        ACT_DISPATCH: begin
                            if (r_cnt != '0 && r_head_ready) begin
                                n_pos   = '0;
                                n_state = S_RM_RD;
                            end else begin
                                n_status = ST_NOTREADY;
                            end
                        end
                        ACT_DELETE: begin
                            if (in_pos_x < cnt_px) begin
                                n_pos   = in_pos_x[CW-1:0];
                                n_state = S_RM_RD;
                            end else begin
                                n_status = ST_BADPOS;
                            end
                        end
                        ACT_CLEAR: begin
                            n_cnt        = '0;
                            n_head_ready = 1'b0;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // tick: count the head down, mark ready at zero
            S_TK_RD: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                n_state   = S_TK_WR;
            end
            S_TK_WR: begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wdata       = rd;
                ram_wdata.delta = u_res;
                if (u_res == 16'd0) n_head_ready = 1'b1;
                n_state = S_FIN;
            end

            // remove: fold the gone delay into the follower, shift the tail down
            S_RM_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_pos[AW-1:0];
                n_state   = S_RM_GONE;
            end
            S_RM_GONE: begin
                n_gone = rd.delta;
                if (r_act == ACT_DISPATCH) begin
                    n_ran    = 1'b1;
                    n_run_id = rd.id;
                    n_id     = rd.id;
                    n_delay  = rd.period;
                    n_period = rd.period;
                end
                n_k = r_pos;
                if (pos_p1 < cnt_x) begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_inc[AW-1:0];
                    n_state   = S_RM_SH;
                end else begin
                    n_state = S_RM_END;
                end
            end
            S_RM_SH: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                ram_wdata = rd;
                if (r_k == r_pos) ram_wdata.delta = u_res;
                n_k = r_k + CW'(1);
                if (k_p2 < cnt_x) begin
                    ram_re    = 1'b1;
                    ram_raddr = k_p2[AW-1:0];
                end else begin
                    n_state = S_RM_END;
                end
            end
            S_RM_END: begin
                n_cnt = cnt_m1;
                if (r_pos == '0) n_head_ready = 1'b0;
                if (r_act == ACT_DISPATCH && r_period != 16'd0) begin
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_FIN;
                end
            end

            // insert: walk the list subtracting deltas
            S_INS_RD: begin
                if (r_cnt >= CW'(MAX_TASKS)) begin
                    n_status = ST_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_rem = r_delay;
                    n_pos = '0;
                    if (r_cnt != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_INS_CMP;
                    end else begin
                        n_state = S_SH_RD;
                    end
                end
            end
            S_INS_CMP: begin
                if (u_carry) begin
                    n_rem = u_res;
                    n_pos = pos_inc;
                    if (pos_p1 < cnt_x) begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_inc[AW-1:0];
                    end else begin
                        n_state = S_SH_RD;
                    end
                end else begin
                    n_state = S_INS_SPLIT;
                end
            end
            S_INS_SPLIT: begin
                n_split = u_res;
                n_state = S_SH_RD;
            end

            // open a slot at the insert point, moving from the tail
            S_SH_RD: begin
                n_k = r_cnt;
                if (r_cnt > r_pos) begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_m1[AW-1:0];
                    n_state   = S_SH_WR;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                ram_wdata = rd;
                if ({1'b0, r_k} == pos_p1) ram_wdata.delta = r_split;
                if ({1'b0, r_k} > pos_p1) begin
                    ram_re    = 1'b1;
                    ram_raddr = k_m2[AW-1:0];
                    n_k       = k_m1;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: begin
                ram_we           = 1'b1;
                ram_waddr        = r_pos[AW-1:0];
                ram_wdata.id     = r_id;
                ram_wdata.delta  = r_rem;
                ram_wdata.period = r_period;
                if (r_pos == '0) n_head_ready = 1'b0;
                n_cnt   = r_cnt + CW'(1);
                n_state = S_FIN;
            end

            S_FIN: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_head_ready <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_head_ready <= n_head_ready;
            r_valid      <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_id     <= n_id;
        r_delay  <= n_delay;
        r_period <= n_period;
        r_rem    <= n_rem;
        r_split  <= n_split;
        r_gone   <= n_gone;
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_status <= n_status;
        r_ran    <= n_ran;
        r_run_id <= n_run_id;
    end

    dlts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // outputs
    assign cnt_out        = {5'b00000, r_cnt};
    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_valid;
    assign o_ran_task     = r_ran;
    assign o_run_id       = r_run_id;
    assign o_status       = r_status;
    assign o_task_count   = cnt_out[4:0];

    // checks
    `DLTS_ASSERT(a_cnt_bound, r_cnt <= CW'(MAX_TASKS))
    `DLTS_ASSERT(a_result_idle, !r_valid || r_state == S_IDLE)
    `DLTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `DLTS_ASSERT(a_full_count, !(r_valid && r_status == ST_FULL) || r_cnt == CW'(MAX_TASKS))
    `DLTS_ASSERT(a_ran_ok, !(r_valid && r_ran) || r_status == ST_OK)

endmodule

// File: rtl/dlts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
